>>> hw/rtl/binary_majority_filter_3x3_defines.svh
// Assertion macros shared by the majority filter RTL.
// No dependencies; included by the top level.
`ifndef BINARY_MAJORITY_FILTER_3X3_DEFINES_SVH
`define BINARY_MAJORITY_FILTER_3X3_DEFINES_SVH

// same-cycle implication
`define BMF_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BMF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/bmf_pkg.sv
// Types and constants of the 3x3 binary majority filter.
// No dependencies.
package bmf_pkg;

    localparam int COORD_W        = 10;
    localparam int CFG_W          = 11;
    localparam int CFG_IDX_W      = 8;
    localparam int FREE_THRESHOLD = 5;
    localparam int Q_DEPTH        = 4;
    localparam int Q_PTR_W        = $clog2(Q_DEPTH);
    localparam int Q_CNT_W        = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);

    // tile in flight between address issue and window update
    typedef struct packed {
        logic               valid;
        logic               tile;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               border;
        logic               interior;
    } stage_t;

    // results caused by one input beat
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               has_int;
        logic               int_free;
        logic               has_bdr;
        logic               tile;
    } entry_t;

endpackage

>>> hw/rtl/bmf_line_mem.sv
// Two-row line store: each entry holds {row-2, row-1} tiles of one column.
// Synchronous read into a registered output. Depends on nothing.
module bmf_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [1:0]    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [1:0]    wr_data
);

    logic [1:0] mem [DEPTH];
    logic [1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/bmf_window.sv
// 3x3 window shift register, popcount and majority decision.
// Depends on bmf_pkg.
module bmf_window (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            clear,
    input  bmf_pkg::stage_t stage,
    input  logic [1:0]      col_bits,
    output logic            push,
    output bmf_pkg::entry_t entry
);

    logic [8:0] window_reg;
    logic [8:0] window_next;
    logic [3:0] ones;

    always_comb begin
        ones = 4'd0;
        for (int i = 0; i < 9; i++) begin
            ones = ones + 4'(window_next[i]);
        end
    end

    assign window_next = {window_reg[5:0], col_bits, stage.tile};

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            window_reg <= 9'd0;
        end else if (stage.valid) begin
            window_reg <= window_next;
        end
    end

    assign push           = stage.valid && (stage.interior || stage.border);
    assign entry.row      = stage.row;
    assign entry.col      = stage.col;
    assign entry.has_int  = stage.interior;
    assign entry.int_free = (ones >= 4'(bmf_pkg::FREE_THRESHOLD));
    assign entry.has_bdr  = stage.border;
    assign entry.tile     = stage.tile;

endmodule

>>> hw/rtl/bmf_out_queue.sv
// Result queue: one entry per input beat that yields results, unpacked into one or two result beats.
// Depends on bmf_pkg.
module bmf_out_queue (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  bmf_pkg::entry_t              push_entry,
    output logic [bmf_pkg::Q_CNT_W-1:0]  count,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [bmf_pkg::COORD_W-1:0]  m_out_row,
    output logic [bmf_pkg::COORD_W-1:0]  m_out_col,
    output logic                         m_out_free,
    output logic                         m_last_of_run
);

    bmf_pkg::entry_t                entries [bmf_pkg::Q_DEPTH];
    logic [bmf_pkg::Q_PTR_W-1:0]    wr_ptr_reg;
    logic [bmf_pkg::Q_PTR_W-1:0]    rd_ptr_reg;
    logic [bmf_pkg::Q_CNT_W-1:0]    count_reg;
    logic [bmf_pkg::Q_CNT_W-1:0]    count_next;
    logic                           phase_reg;
    bmf_pkg::entry_t                head;
    logic                           sel_int;
    logic                           beat;
    logic                           pop;

    assign head    = entries[rd_ptr_reg];
    assign sel_int = head.has_int && !phase_reg;
    assign m_valid = (count_reg != '0);
    assign beat    = m_valid && m_ready;
    assign pop     = beat && !(sel_int && head.has_bdr);
    assign count   = count_reg;

    assign m_out_row     = sel_int ? head.row - 1'b1 : head.row;
    assign m_out_col     = sel_int ? head.col - 1'b1 : head.col;
    assign m_out_free    = sel_int ? head.int_free : head.tile;
    assign m_last_of_run = sel_int ? !head.has_bdr : 1'b1;

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            phase_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
                phase_reg  <= 1'b0;
            end else if (beat) begin
                phase_reg  <= 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/binary_majority_filter_3x3.sv
// Top level of the 3x3 binary majority filter: position counters, config
// registers, line store read stage. Depends on bmf_pkg, bmf_line_mem,
// bmf_window, bmf_out_queue and binary_majority_filter_3x3_defines.svh.
//
// Usage:
//   s_* carries one tile per beat in raster order; m_* carries result beats
//   (row, column, smoothed value, last_of_run). cfg_* writes grid_width
//   (index 0) or grid_height (index 1); a write restarts the map at row 0,
//   column 0 and clears the window. cfg_ready is always high.
//   Each input beat yields zero, one or two result beats: the completed
//   interior tile first, then the arriving border tile.
//   An accepted tile is registered in the read stage, then in the queue.
//   Throughput: one tile per cycle while s_ready is high; the line store is
//   read in the cycle before the window update and written back in that
//   update cycle. Output is one result beat per cycle while m_ready is high;
//   a four-entry result queue absorbs the pair at the right column; on the
//   last row it fills. s_ready drops when queue plus read stage would fill it.
//   Receiver stall: results hold in the queue and s_ready falls once full.
//   Reset: position 0,0, window cleared, queue empty, both dimensions 64
//   (limited to MAX_WIDTH/MAX_HEIGHT). The line store is not cleared.
`include "binary_majority_filter_3x3_defines.svh"

module binary_majority_filter_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_tile_free,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bmf_pkg::COORD_W-1:0]     m_out_row,
    output logic [bmf_pkg::COORD_W-1:0]     m_out_col,
    output logic                            m_out_free,
    output logic                            m_last_of_run,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bmf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bmf_pkg::CFG_W-1:0]       cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WCMP = ($clog2(MAX_WIDTH + 1) > bmf_pkg::CFG_W) ?
                          $clog2(MAX_WIDTH + 1) : bmf_pkg::CFG_W;
    localparam int HCMP = ($clog2(MAX_HEIGHT + 1) > bmf_pkg::CFG_W) ?
                          $clog2(MAX_HEIGHT + 1) : bmf_pkg::CFG_W;
    localparam logic [CW-1:0] W_LAST_RST = CW'(((MAX_WIDTH < 64) ? MAX_WIDTH : 64) - 1);
    localparam logic [RW-1:0] H_LAST_RST = RW'(((MAX_HEIGHT < 64) ? MAX_HEIGHT : 64) - 1);

    logic [CW-1:0]              w_last_reg;
    logic [RW-1:0]              h_last_reg;
    logic [CW-1:0]              col_reg;
    logic [RW-1:0]              row_reg;
    logic [CW-1:0]              s1_addr_reg;
    bmf_pkg::stage_t            s1_reg;
    bmf_pkg::stage_t            s1_next;
    logic                       s_beat;
    logic                       cfg_beat;
    logic                       restart;
    logic [WCMP-1:0]            w_data;
    logic [HCMP-1:0]            h_data;
    logic [CW-1:0]              w_last_next;
    logic [RW-1:0]              h_last_next;
    logic [1:0]                 col_bits;
    logic                       push;
    bmf_pkg::entry_t            push_entry;
    logic [bmf_pkg::Q_CNT_W-1:0] q_count;

    assign cfg_ready = 1'b1;
    assign cfg_beat  = cfg_valid && cfg_ready;
    assign restart   = cfg_beat && ((cfg_index == bmf_pkg::REG_GRID_WIDTH) ||
                                    (cfg_index == bmf_pkg::REG_GRID_HEIGHT));

    assign s_ready = ((bmf_pkg::Q_CNT_W + 1)'(q_count) + (bmf_pkg::Q_CNT_W + 1)'(s1_reg.valid))
                     < (bmf_pkg::Q_CNT_W + 1)'(bmf_pkg::Q_DEPTH);
    assign s_beat  = s_valid && s_ready;

    assign w_data = WCMP'(cfg_data);
    assign h_data = HCMP'(cfg_data);

    always_comb begin
        if (w_data < WCMP'(3)) begin
            w_last_next = CW'(2);
        end else if (w_data > WCMP'(MAX_WIDTH)) begin
            w_last_next = CW'(MAX_WIDTH - 1);
        end else begin
            w_last_next = CW'(w_data - 1'b1);
        end
        if (h_data < HCMP'(3)) begin
            h_last_next = RW'(2);
        end else if (h_data > HCMP'(MAX_HEIGHT)) begin
            h_last_next = RW'(MAX_HEIGHT - 1);
        end else begin
            h_last_next = RW'(h_data - 1'b1);
        end
    end

    always_comb begin
        s1_next.valid    = s_beat;
        s1_next.tile     = s_tile_free;
        s1_next.row      = bmf_pkg::COORD_W'(row_reg);
        s1_next.col      = bmf_pkg::COORD_W'(col_reg);
        s1_next.border   = (row_reg == '0) || (col_reg == '0) ||
                           (row_reg == h_last_reg) || (col_reg == w_last_reg);
        s1_next.interior = (row_reg >= RW'(2)) && (col_reg >= CW'(2));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_last_reg   <= W_LAST_RST;
            h_last_reg   <= H_LAST_RST;
            col_reg      <= '0;
            row_reg      <= '0;
        end else begin
            if (cfg_beat && (cfg_index == bmf_pkg::REG_GRID_WIDTH)) begin
                w_last_reg <= w_last_next;
            end
            if (cfg_beat && (cfg_index == bmf_pkg::REG_GRID_HEIGHT)) begin
                h_last_reg <= h_last_next;
            end
            if (restart) begin
                col_reg <= '0;
                row_reg <= '0;
            end else if (s_beat) begin
                if (col_reg == w_last_reg) begin
                    col_reg <= '0;
                    row_reg <= (row_reg == h_last_reg) ? '0 : row_reg + 1'b1;
                end else begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
        end else begin
            s1_reg.valid <= s1_next.valid;
        end
        if (s_beat) begin
            s1_addr_reg       <= col_reg;
            s1_reg.tile       <= s1_next.tile;
            s1_reg.row        <= s1_next.row;
            s1_reg.col        <= s1_next.col;
            s1_reg.border     <= s1_next.border;
            s1_reg.interior   <= s1_next.interior;
        end
    end

    bmf_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_mem (
        .aclk    (aclk),
        .rd_en   (s_beat),
        .rd_addr (col_reg),
        .rd_data (col_bits),
        .wr_en   (s1_reg.valid),
        .wr_addr (s1_addr_reg),
        .wr_data ({col_bits[0], s1_reg.tile})
    );

    bmf_window u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (restart),
        .stage    (s1_reg),
        .col_bits (col_bits),
        .push     (push),
        .entry    (push_entry)
    );

    bmf_out_queue u_out_queue (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (push),
        .push_entry    (push_entry),
        .count         (q_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_out_free    (m_out_free),
        .m_last_of_run (m_last_of_run)
    );

    `BMF_ASSERT_NOW(a_no_rw_collision, aclk, aresetn, s_beat && s1_reg.valid,
        col_reg != s1_addr_reg, "line store read and write hit the same column")

    `BMF_ASSERT_NOW(a_queue_no_overflow, aclk, aresetn, push,
        q_count < bmf_pkg::Q_CNT_W'(bmf_pkg::Q_DEPTH), "result queue overflow")

    `BMF_ASSERT_NEXT(a_beat_reaches_stage, aclk, aresetn, s_beat,
        s1_reg.valid, "accepted tile missing from read stage")

endmodule

>>> verif/binary_majority_filter_3x3_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for binary_majority_filter_3x3: streams tile maps in raster
// order, predicts every result beat, and checks them in arrival order.
// Depends on bmf_pkg and the binary_majority_filter_3x3 RTL.
module binary_majority_filter_3x3_test;

    localparam int GRID_MAX_W     = 1024;
    localparam int GRID_MAX_H     = 1024;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_TILES   = 320;

    localparam logic [bmf_pkg::CFG_IDX_W-1:0] REG_UNUSED  = bmf_pkg::CFG_IDX_W'(2);
    localparam logic [bmf_pkg::CFG_IDX_W-1:0] REG_IDX_TOP = '1;

    typedef struct packed {
        logic [bmf_pkg::COORD_W-1:0] row;
        logic [bmf_pkg::COORD_W-1:0] col;
        logic                        free;
        logic                        last;
    } tile_beat_t;

    logic                          aclk          = 1'b0;
    logic                          aresetn       = 1'b0;
    logic                          s_valid       = 1'b0;
    logic                          s_ready;
    logic                          s_tile_free   = 1'b0;
    logic                          m_valid;
    logic                          m_ready       = 1'b0;
    logic [bmf_pkg::COORD_W-1:0]   m_out_row;
    logic [bmf_pkg::COORD_W-1:0]   m_out_col;
    logic                          m_out_free;
    logic                          m_last_of_run;
    logic                          cfg_valid     = 1'b0;
    logic                          cfg_ready;
    logic [bmf_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
    logic [bmf_pkg::CFG_W-1:0]     cfg_data      = '0;

    // predicted state of the filter
    bit                            row_above[GRID_MAX_W];
    bit                            row_above2[GRID_MAX_W];
    bit [8:0]                      window_q;
    int                            next_col;
    int                            next_row;
    logic [bmf_pkg::CFG_W-1:0]     width_reg  = bmf_pkg::CFG_W'(64);
    logic [bmf_pkg::CFG_W-1:0]     height_reg = bmf_pkg::CFG_W'(64);

    tile_beat_t           expected_beats[$];

    int                   mismatches   = 0;
    int                   tiles_sent   = 0;
    int                   beats_seen   = 0;
    int                   reg_writes   = 0;
    int                   burst_left   = 0;
    int                   rx_hold      = 0;
    int                   idle_cycles  = 0;
    bit                   tx_gaps_on   = 1'b1;
    bit                   rx_stall_on  = 1'b1;

    binary_majority_filter_3x3 #(
        .MAX_WIDTH  (GRID_MAX_W),
        .MAX_HEIGHT (GRID_MAX_H)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_tile_free   (s_tile_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_out_free    (m_out_free),
        .m_last_of_run (m_last_of_run),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic int clamp_dim(input logic [bmf_pkg::CFG_W-1:0] v, input int hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    task automatic smooth_tile(input logic t);
        int         w;
        int         h;
        int         c;
        int         r;
        bit [2:0]   column;
        bit         border;
        tile_beat_t beat;
        w = clamp_dim(width_reg, GRID_MAX_W);
        h = clamp_dim(height_reg, GRID_MAX_H);
        c = (next_col >= w) ? w - 1 : next_col;
        r = (next_row >= h) ? h - 1 : next_row;
        column = {row_above2[c], row_above[c], t};
        row_above2[c] = row_above[c];
        row_above[c]  = t;
        window_q = {window_q[5:0], column};
        border = (r == 0) || (c == 0) || (r == h - 1) || (c == w - 1);
        if (r >= 2 && c >= 2) begin
            beat.row  = bmf_pkg::COORD_W'(r - 1);
            beat.col  = bmf_pkg::COORD_W'(c - 1);
            beat.free = ($countones(window_q) >= bmf_pkg::FREE_THRESHOLD);
            beat.last = !border;
            expected_beats.push_back(beat);
        end
        if (border) begin
            beat.row  = bmf_pkg::COORD_W'(r);
            beat.col  = bmf_pkg::COORD_W'(c);
            beat.free = t;
            beat.last = 1'b1;
            expected_beats.push_back(beat);
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        next_col = c;
        next_row = r;
    endtask

    task automatic send_tile(input logic t);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (tx_gaps_on) gap = $urandom_range(1, 10);
        end
        burst_left--;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_tile_free <= t;
        do @(posedge aclk); while (!s_ready);
        smooth_tile(t);
        tiles_sent++;
    endtask

    task automatic send_random_tiles(input int count, input int unsigned density);
        repeat (count) send_tile($urandom_range(0, 99) < density);
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_beats.size() != 0);
    endtask

    task automatic wait_idle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [bmf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bmf_pkg::CFG_W-1:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        if (idx == bmf_pkg::REG_GRID_WIDTH || idx == bmf_pkg::REG_GRID_HEIGHT) begin
            if (idx == bmf_pkg::REG_GRID_WIDTH) width_reg = data;
            else height_reg = data;
            next_col = 0;
            next_row = 0;
            window_q = '0;
        end
    endtask

    // result beat checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (expected_beats.size() == 0) begin
                $error("unexpected result beat row %0d col %0d", m_out_row, m_out_col);
                mismatches++;
            end else begin
                if (m_out_row !== expected_beats[0].row) begin
                    $error("out_row: expected %0d, got %0d", expected_beats[0].row, m_out_row);
                    mismatches++;
                end
                if (m_out_col !== expected_beats[0].col) begin
                    $error("out_col: expected %0d, got %0d", expected_beats[0].col, m_out_col);
                    mismatches++;
                end
                if (m_out_free !== expected_beats[0].free) begin
                    $error("out_free: expected %0b, got %0b", expected_beats[0].free,
                           m_out_free);
                    mismatches++;
                end
                if (m_last_of_run !== expected_beats[0].last) begin
                    $error("last_of_run: expected %0b, got %0b", expected_beats[0].last,
                           m_last_of_run);
                    mismatches++;
                end
                void'(expected_beats.pop_front());
            end
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (!rx_stall_on) begin
            m_ready <= 1'b1;
        end else if (rx_hold == 0) begin
            m_ready <= ($urandom_range(0, 99) < 65);
            rx_hold <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 8);
        end else begin
            rx_hold <= rx_hold - 1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // default 64x64 grid after reset: first row is all border
    task automatic test_reset_size();
        send_tile(1'b1);
        send_tile(1'b0);
        send_tile(1'b1);
        send_tile(1'b1);
        send_tile(1'b0);
    endtask

    // clamped 3x3 maps: threshold hit and miss, map wrap, unused register index
    task automatic test_small_maps();
        logic [8:0] hit;
        logic [8:0] miss;
        hit  = 9'b101010101;
        miss = 9'b010101010;
        write_reg(bmf_pkg::REG_GRID_WIDTH, bmf_pkg::CFG_W'(0));
        write_reg(bmf_pkg::REG_GRID_HEIGHT, bmf_pkg::CFG_W'(1));
        for (int i = 0; i < 9; i++) send_tile(hit[i]);
        for (int i = 0; i < 4; i++) send_tile(miss[i]);
        write_reg(REG_IDX_TOP, '1);
        write_reg(REG_UNUSED, bmf_pkg::CFG_W'(3));
        for (int i = 4; i < 9; i++) send_tile(miss[i]);
    endtask

    // dimensions beyond the maximum clamp to 1024
    task automatic test_clamp_high();
        write_reg(bmf_pkg::REG_GRID_WIDTH, '1);
        write_reg(bmf_pkg::REG_GRID_HEIGHT, bmf_pkg::CFG_W'(0));
        send_random_tiles(200, 50);
        wait_results();
        send_random_tiles(100, 50);
        write_reg(bmf_pkg::REG_GRID_WIDTH, bmf_pkg::CFG_W'(3));
        write_reg(bmf_pkg::REG_GRID_HEIGHT, bmf_pkg::CFG_W'(1025));
        send_random_tiles(60, $urandom_range(20, 80));
    endtask

    task automatic test_random();
        int          start;
        int          w;
        int          h;
        int          count;
        int unsigned pick;
        int unsigned density;
        bit          first;
        start = tiles_sent;
        first = 1'b1;
        while (tiles_sent - start < RANDOM_TILES) begin
            tx_gaps_on  = ($urandom_range(0, 9) < 7);
            rx_stall_on = ($urandom_range(0, 9) < 7);
            if ($urandom_range(0, 5) == 0)
                write_reg(bmf_pkg::CFG_IDX_W'($urandom_range(2, 255)),
                          bmf_pkg::CFG_W'($urandom));
            pick = $urandom_range(0, 9);
            if (first || pick < 8) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) w = $urandom_range(0, 2);
                else if (pick < 7) w = $urandom_range(3, 8);
                else if (pick < 9) w = $urandom_range(9, 24);
                else w = $urandom_range(25, 64);
                write_reg(bmf_pkg::REG_GRID_WIDTH, bmf_pkg::CFG_W'(w));
            end
            if (first || pick >= 2) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) h = $urandom_range(0, 2);
                else if (pick < 8) h = $urandom_range(3, 6);
                else h = $urandom_range(7, 12);
                write_reg(bmf_pkg::REG_GRID_HEIGHT, bmf_pkg::CFG_W'(h));
            end
            first = 1'b0;
            w = clamp_dim(width_reg, GRID_MAX_W);
            h = clamp_dim(height_reg, GRID_MAX_H);
            if ($urandom_range(0, 2) == 0) count = $urandom_range(1, w * h);
            else count = w * h * $urandom_range(1, 2) + $urandom_range(0, 2 * w);
            if (count > 200) count = 200;
            if (count > RANDOM_TILES - (tiles_sent - start))
                count = RANDOM_TILES - (tiles_sent - start);
            density = $urandom_range(0, 100);
            for (int i = 0; i < count; i++) begin
                if ($urandom_range(0, 99) < 2) wait_results();
                send_tile($urandom_range(0, 99) < density);
            end
        end
    endtask

    initial begin
        window_q = '0;
        next_col = 0;
        next_row = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_size();
        test_small_maps();
        test_clamp_high();
        test_random();
        wait_results();
        repeat (4 * SETTLE_CYCLES) @(posedge aclk);
        $display("Sent %0d tiles, checked %0d result beats, %0d register writes",
                 tiles_sent, beats_seen, reg_writes);
        $display("Grids ranged from clamped 3x3 maps to clamped 1024-wide and 1024-high maps");
        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/bmf_pkg.sv
hw/rtl/bmf_line_mem.sv
hw/rtl/bmf_window.sv
hw/rtl/bmf_out_queue.sv
hw/rtl/binary_majority_filter_3x3.sv
verif/binary_majority_filter_3x3_test.sv
